@@ rtl/ecnp_pkg.sv @@
`default_nettype none
package ecnp_pkg;

    // width of the node id fields on the ports
    localparam int FIELD_BITS = 24;

    // defaults for the top level parameters
    localparam int MAX_EDGES_DEF = 32;
    localparam int NODE_BITS_DEF = 24;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // edge beat accepted
        logic seed_cap;    // take edge 0 as front and back, write front node
        logic seed_back;   // write back node after the front
        logic scan;        // scan the edge store for the selected end
        logic scan_side;   // 0 front, 1 back
        logic round_next;  // one round finished
        logic emit_start;  // point the read pointer at the path head
        logic out_load;    // load the output register from the path store
        logic emit_next;   // step the read pointer
        logic clear_set;   // drop per-set state after the last node
    } t_ecnp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic front_done;
        logic back_done;
        logic rounds_done;
        logic emit_last;
        logic out_taken;
    } t_ecnp_sts;

endpackage
`default_nettype wire

@@ rtl/ecnp_edge_if.sv @@
`default_nettype none
interface ecnp_edge_if;
    logic                             valid;
    logic                             ready;
    logic [ecnp_pkg::FIELD_BITS-1:0] edge_first_node;
    logic [ecnp_pkg::FIELD_BITS-1:0] edge_second_node;
    logic                             last_edge;

    modport source (
        output valid, edge_first_node, edge_second_node, last_edge,
        input  ready
    );
    modport sink (
        input  valid, edge_first_node, edge_second_node, last_edge,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/ecnp_node_if.sv @@
`default_nettype none
interface ecnp_node_if;
    logic                             valid;
    logic                             ready;
    logic [ecnp_pkg::FIELD_BITS-1:0] node_id;
    logic                             last_node;
    logic                             overflow;

    modport source (
        output valid, node_id, last_node, overflow,
        input  ready
    );
    modport sink (
        input  valid, node_id, last_node, overflow,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/ecnp_ram.sv @@
`default_nettype none
module ecnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/ecnp_ctrl.sv @@
`default_nettype none
module ecnp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_last,
    output logic                      o_in_ready,
    input  wire ecnp_pkg::t_ecnp_sts  i_sts,
    output ecnp_pkg::t_ecnp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_RD,
        S_SEED_CAP,
        S_SEED_BACK,
        S_ROUND,
        S_F_SCAN,
        S_B_SCAN,
        S_EMIT_START,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_scan_end;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_scan_end = i_sts.scan_hit || i_sts.scan_miss;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_SEED_RD;
                    end
                end
            end
            S_SEED_RD: begin
                n_state = S_SEED_CAP;
            end
            S_SEED_CAP: begin
                o_cmd.seed_cap = 1'b1;
                n_state        = S_SEED_BACK;
            end
            S_SEED_BACK: begin
                o_cmd.seed_back = 1'b1;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                n_state = i_sts.rounds_done ? S_EMIT_START : S_F_SCAN;
            end
            S_F_SCAN: begin
                if (i_sts.front_done) begin
                    n_state = S_B_SCAN;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (w_scan_end) begin
                        n_state = S_B_SCAN;
                    end
                end
            end
            S_B_SCAN: begin
                if (i_sts.back_done) begin
                    o_cmd.round_next = 1'b1;
                    n_state          = S_ROUND;
                end else begin
                    o_cmd.scan      = 1'b1;
                    o_cmd.scan_side = 1'b1;
                    if (w_scan_end) begin
                        o_cmd.round_next = 1'b1;
                        n_state          = S_ROUND;
                    end
                end
            end
            S_EMIT_START: begin
                o_cmd.emit_start = 1'b1;
                n_state          = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.emit_last) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ecnp_dpath.sv @@
`default_nettype none
module ecnp_dpath #(
    parameter int MAX_EDGES = ecnp_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = ecnp_pkg::NODE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ecnp_pkg::t_ecnp_cmd               i_cmd,
    output ecnp_pkg::t_ecnp_sts                    o_sts,
    input  wire logic [ecnp_pkg::FIELD_BITS-1:0]   i_first_node,
    input  wire logic [ecnp_pkg::FIELD_BITS-1:0]   i_second_node,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [ecnp_pkg::FIELD_BITS-1:0]   o_node_id,
    output logic                                   o_last_node,
    output logic                                   o_overflow
);

    localparam int CW         = $clog2(MAX_EDGES + 1);
    localparam int AW         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PATH_DEPTH = 2 * MAX_EDGES + 1;
    localparam int PAW        = $clog2(PATH_DEPTH);
    localparam int FB         = ecnp_pkg::FIELD_BITS;

    // per-set counters and flags
    logic [CW-1:0]        r_edge_count;
    logic                 r_dropped;
    logic [MAX_EDGES-1:0] r_used;
    logic [CW-1:0]        r_round;
    logic                 r_front_done;
    logic                 r_back_done;

    // path ends and path store pointers
    logic [NODE_BITS-1:0] r_front;
    logic [NODE_BITS-1:0] r_back;
    logic [PAW-1:0]       r_head;
    logic [PAW-1:0]       r_tail;
    logic [PAW-1:0]       r_emit_addr;

    // scan pipeline: issue index, then compare against the ram data in the next cycle
    logic [CW-1:0]        r_scan_idx;
    logic [AW-1:0]        r_cmp_idx;
    logic                 r_cmp_vld;

    logic                 w_edge_we;
    logic [63:0]          w_first_w;
    logic [63:0]          w_second_w;
    logic [2*NODE_BITS-1:0] w_edge_wdata;
    logic [2*NODE_BITS-1:0] w_edge_rdata;
    logic [NODE_BITS-1:0] w_e_start;
    logic [NODE_BITS-1:0] w_e_end;
    logic [NODE_BITS-1:0] w_end_val;
    logic                 w_match_s;
    logic                 w_match_e;
    logic [NODE_BITS-1:0] w_other;
    logic                 w_hit;
    logic                 w_miss;

    logic                 w_path_we;
    logic [PAW-1:0]       w_path_waddr;
    logic [NODE_BITS-1:0] w_path_wdata;
    logic [NODE_BITS-1:0] w_path_rdata;
    logic [63:0]          w_path_rw;

    assign w_first_w    = 64'(i_first_node);
    assign w_second_w   = 64'(i_second_node);
    assign w_edge_wdata = {w_first_w[NODE_BITS-1:0], w_second_w[NODE_BITS-1:0]};
    assign w_edge_we    = i_cmd.load && (r_edge_count < CW'(MAX_EDGES));

    ecnp_ram #(
        .WIDTH (2 * NODE_BITS),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_edge_we),
        .i_wr_addr (r_edge_count[AW-1:0]),
        .i_wr_data (w_edge_wdata),
        .i_rd_addr (r_scan_idx[AW-1:0]),
        .o_rd_data (w_edge_rdata)
    );

    assign w_e_start = w_edge_rdata[2*NODE_BITS-1:NODE_BITS];
    assign w_e_end   = w_edge_rdata[NODE_BITS-1:0];
    assign w_end_val = i_cmd.scan_side ? r_back : r_front;
    assign w_match_s = (w_e_start == w_end_val);
    assign w_match_e = (w_e_end == w_end_val);
    assign w_other   = w_match_s ? w_e_end : w_e_start;

    // first endpoint wins when both touch the end
    assign w_hit  = i_cmd.scan && r_cmp_vld && !r_used[r_cmp_idx] && (w_match_s || w_match_e);
    assign w_miss = i_cmd.scan && !r_cmp_vld && (r_scan_idx == r_edge_count);

    always_comb begin
        w_path_we    = 1'b0;
        w_path_waddr = r_tail;
        w_path_wdata = r_back;
        if (i_cmd.seed_cap) begin
            w_path_we    = 1'b1;
            w_path_waddr = PAW'(MAX_EDGES);
            w_path_wdata = w_e_start;
        end else if (i_cmd.seed_back) begin
            w_path_we    = 1'b1;
            w_path_waddr = PAW'(MAX_EDGES + 1);
            w_path_wdata = r_back;
        end else if (w_hit) begin
            w_path_we    = 1'b1;
            w_path_wdata = w_other;
            w_path_waddr = i_cmd.scan_side ? (r_tail + PAW'(1)) : (r_head - PAW'(1));
        end
    end

    ecnp_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_path_we),
        .i_wr_addr (w_path_waddr),
        .i_wr_data (w_path_wdata),
        .i_rd_addr (r_emit_addr),
        .o_rd_data (w_path_rdata)
    );

    assign w_path_rw = 64'(w_path_rdata);

    assign o_sts.scan_hit    = w_hit;
    assign o_sts.scan_miss   = w_miss;
    assign o_sts.front_done  = r_front_done;
    assign o_sts.back_done   = r_back_done;
    assign o_sts.rounds_done = (r_round == r_edge_count) || (r_front_done && r_back_done);
    assign o_sts.emit_last   = (r_emit_addr == r_tail);
    assign o_sts.out_taken   = o_out_valid && i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_dropped    <= 1'b0;
            r_used       <= '0;
            r_round      <= '0;
            r_front_done <= 1'b0;
            r_back_done  <= 1'b0;
            r_head       <= PAW'(MAX_EDGES);
            r_tail       <= PAW'(MAX_EDGES);
            r_emit_addr  <= '0;
            r_scan_idx   <= '0;
            r_cmp_vld    <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_edge_we) begin
                    r_edge_count <= r_edge_count + CW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end

            if (i_cmd.seed_cap) begin
                r_used[0]    <= 1'b1;
                r_round      <= '0;
                r_front_done <= 1'b0;
                r_back_done  <= 1'b0;
                r_head       <= PAW'(MAX_EDGES);
                r_tail       <= PAW'(MAX_EDGES);
            end
            if (i_cmd.seed_back) begin
                r_tail <= PAW'(MAX_EDGES + 1);
            end

            if (w_hit) begin
                r_used[r_cmp_idx] <= 1'b1;
                if (i_cmd.scan_side) begin
                    r_tail <= r_tail + PAW'(1);
                end else begin
                    r_head <= r_head - PAW'(1);
                end
            end
            if (w_miss) begin
                if (i_cmd.scan_side) begin
                    r_back_done <= 1'b1;
                end else begin
                    r_front_done <= 1'b1;
                end
            end
            if (i_cmd.round_next) begin
                r_round <= r_round + CW'(1);
            end

            // scan issue: restart from edge 0 whenever a scan ends or is idle
            if (!i_cmd.scan || w_hit || w_miss) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (r_scan_idx < r_edge_count) begin
                r_scan_idx <= r_scan_idx + CW'(1);
                r_cmp_vld  <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end

            if (i_cmd.emit_start) begin
                r_emit_addr <= r_head;
            end else if (i_cmd.emit_next) begin
                r_emit_addr <= r_emit_addr + PAW'(1);
            end

            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_sts.out_taken) begin
                o_out_valid <= 1'b0;
            end

            if (i_cmd.clear_set) begin
                r_edge_count <= '0;
                r_dropped    <= 1'b0;
                r_used       <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_idx[AW-1:0];
        if (i_cmd.seed_cap) begin
            r_front <= w_e_start;
            r_back  <= w_e_end;
        end else if (w_hit) begin
            if (i_cmd.scan_side) begin
                r_back <= w_other;
            end else begin
                r_front <= w_other;
            end
        end
        if (i_cmd.out_load) begin
            o_node_id   <= w_path_rw[FB-1:0];
            o_last_node <= o_sts.emit_last;
            o_overflow  <= r_dropped;
        end
    end

endmodule
`default_nettype wire

@@ rtl/edge_chain_to_node_path.sv @@
// sequence: edge beats are taken one per cycle while idle; after the closing edge the path is
//   seeded from edge 0, then up to N rounds of a check state plus a front and a back scan run
//   over the stored edges, then the walk reads, loads and holds each path node until taken
// throughput: one edge set at a time; the scan rate is set by the single read port of the
//   edge ram, one edge compared per cycle
// reset: synchronous, active low; clears control state, edge and path rams are not cleared
`default_nettype none
module edge_chain_to_node_path #(
    parameter int MAX_EDGES = ecnp_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = ecnp_pkg::NODE_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ecnp_edge_if.sink    i_edge,
    ecnp_node_if.source  o_node
);

    // command and status between sequencer and datapath
    ecnp_pkg::t_ecnp_cmd w_cmd;
    ecnp_pkg::t_ecnp_sts w_sts;

    // sequencer: takes edge beats while idle, seeds the path after the closing beat,
    // alternates front and back scans per round, then walks the path store
    ecnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .i_in_last  (i_edge.last_edge),
        .o_in_ready (i_edge.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: edge ram, used bits, path ends, path ram and the output register
    ecnp_dpath #(
        .MAX_EDGES (MAX_EDGES),
        .NODE_BITS (NODE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_first_node  (i_edge.edge_first_node),
        .i_second_node (i_edge.edge_second_node),
        .o_out_valid   (o_node.valid),
        .i_out_ready   (o_node.ready),
        .o_node_id     (o_node.node_id),
        .o_last_node   (o_node.last_node),
        .o_overflow    (o_node.overflow)
    );

endmodule
`default_nettype wire

@@ rtl/ecnp_checker.sv @@
`default_nettype none
module ecnp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_last,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last,
    input wire logic [ecnp_pkg::FIELD_BITS-1:0] i_out_node
);

    // a beat waiting on the output holds its node
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_node))
        else $error("output beat dropped or changed while stalled");

    // edges are never taken while nodes are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("edge input open during node output");

    // a non-closing edge leaves the input open
    a_keep_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> i_in_ready)
        else $error("input closed after a non-closing edge");

    // the closing edge starts chaining: no edge, no node next cycle
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready && !i_out_valid)
        else $error("closing edge not followed by chaining");

    // the last node ends the set
    a_last_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid && i_in_ready)
        else $error("output continued after the last node");

endmodule

bind edge_chain_to_node_path ecnp_checker u_ecnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_edge.valid),
    .i_in_ready  (i_edge.ready),
    .i_in_last   (i_edge.last_edge),
    .i_out_valid (o_node.valid),
    .i_out_ready (o_node.ready),
    .i_out_last  (o_node.last_node),
    .i_out_node  (o_node.node_id)
);
`default_nettype wire
